// ----- rtl/core/fcad_pkg.sv -----
// Shared types, constants and the CRC-16/MODBUS byte step for the frame decoder.
// No dependencies; imported by fcad_scale and encoder_frame_crc_angle_decoder.
`default_nettype none

package fcad_pkg;

  // Frame layout: bytes 0..6 are covered by the CRC, 4..6 carry the position,
  // 7..8 carry the little-endian check word.
  localparam logic [3:0] FRAME_LEN   = 4'd9;
  localparam logic [3:0] CRC_BYTES   = 4'd7;
  localparam logic [3:0] IDX_POS_HI  = 4'd4;
  localparam logic [3:0] IDX_POS_MID = 4'd5;
  localparam logic [3:0] IDX_POS_LO  = 4'd6;
  localparam logic [3:0] IDX_CHK_LO  = 4'd7;
  localparam logic [3:0] IDX_CHK_HI  = 4'd8;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Offset register reset: -151.363 degrees in Q16
  localparam logic [25:0] OFFSET_RESET = 26'h368A312;

  // floor(y/7) for y below 2**26: (y * RECIP7) >> RECIP7_SHIFT is low by at most one
  localparam int unsigned     RECIP7_SHIFT = 29;
  localparam logic [26:0]     RECIP7       = 27'd76695844;
  localparam logic [3:0]      DIVISOR      = 4'd7;

  // Configuration register indexes
  localparam logic REG_ANGLE_OFFSET = 1'b0;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CRC_ERR = 2'd1,
    ST_SHORT   = 2'd2
  } status_t;

  // One byte of CRC-16/MODBUS, LSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/fcad_scale.sv -----
// Two-stage scaler: scaled = floor(raw * 144 / 7), by reciprocal multiply and one correction.
// Depends on fcad_pkg for the reciprocal constants.
`default_nettype none

module fcad_scale (
  input  wire logic        clk,
  input  wire logic [23:0] raw,
  output logic      [28:0] scaled
);
  import fcad_pkg::*;

  // raw*144/7 = 20*raw + floor(4*raw/7)
  logic [25:0] y;
  logic [52:0] prod_nxt;
  logic [52:0] prod_r;
  logic [25:0] y_r;
  logic [23:0] raw_r;
  logic [23:0] q0;
  logic [26:0] times7;
  logic [26:0] rem;
  logic [23:0] q;
  logic [28:0] scaled_nxt;
  logic [28:0] scaled_r;

  assign y        = {raw, 2'b00};
  assign prod_nxt = 53'(y) * 53'(RECIP7);

  // Stage A: register the product
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    y_r    <= y;
    raw_r  <= raw;
  end

  // Stage B: correct the estimate and add the integer part
  assign q0         = prod_r[RECIP7_SHIFT +: 24];
  assign times7     = {q0, 3'b000} - 27'(q0);
  assign rem        = 27'(y_r) - times7;
  assign q          = q0 + 24'((rem >= 27'(DIVISOR)) ? 1 : 0);
  assign scaled_nxt = {1'b0, raw_r, 4'b0000} + {3'b000, raw_r, 2'b00} + 29'(q);

  always_ff @(posedge clk) begin
    scaled_r <= scaled_nxt;
  end

  assign scaled = scaled_r;

endmodule

`default_nettype wire

// ----- rtl/core/encoder_frame_crc_angle_decoder.sv -----
// Top level of the checked-frame encoder decoder: input register, frame state, result register.
// Depends on fcad_pkg and fcad_scale.
`default_nettype none

// Usage:
//   Input channel (in_valid/in_ready) carries one word per UART event: a data byte
//   (in_idle_event low) or an idle-line event (in_idle_event high) that closes a frame.
//   Data words give no result; each idle word gives exactly one result word on the
//   output channel (out_valid/out_ready): status, turns, fine and angle_q16.
//   Flow: a word is accepted into an input register and processed from there; an idle
//   word's result is loaded into the result register that drives out_*. Throughput is
//   one word per cycle while no idle word waits; the CRC step is unrolled over the byte.
//   The angle is computed by a two-stage reciprocal multiplier that tracks the stored
//   position continuously; a frame's position bytes precede its idle word by at least
//   three words, so the scaled value is always settled when the frame closes.
//   When out_ready is low the result register holds; data words keep flowing, and an
//   idle word waits in the input register, which then drops in_ready.
//   The APB port holds angle_offset_q16 at address 0; write it only while idle.
//   Reset (rst_n low, synchronous) empties both registers, restarts the frame,
//   clears the stored position and angle and loads the default offset.

module encoder_frame_crc_angle_decoder (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_data_byte,
  input  wire logic               in_idle_event,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_status,
  output logic [11:0]             out_turns,
  output logic [11:0]             out_fine,
  output logic signed [29:0]      out_angle_q16,
  // configuration port
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [2:0]         cfg_paddr,
  input  wire logic [31:0]        cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);
  import fcad_pkg::*;

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_idle_r;
  logic        s1_go;

  logic [3:0]  byte_index_r;
  logic [15:0] running_crc_r;
  logic [23:0] raw_position_r;
  logic [15:0] check_word_r;
  logic [23:0] good_position_r;
  logic [29:0] good_angle_r;
  logic [25:0] offset_r;

  logic [28:0] scaled;
  logic [29:0] angle_sum;
  status_t     status_nxt;

  logic        out_valid_r;
  status_t     out_status_r;
  logic [11:0] out_turns_r;
  logic [11:0] out_fine_r;
  logic [29:0] out_angle_r;

  logic        cfg_write;

  // Configuration: write the offset on the access phase
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_ANGLE_OFFSET) ?
                      {{6{offset_r[25]}}, offset_r} : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= OFFSET_RESET;
    end else if (cfg_write && (cfg_paddr[2] == REG_ANGLE_OFFSET)) begin
      offset_r <= cfg_pwdata[25:0];
    end
  end

  // Input register advances unless an idle word is blocked by a full result register
  assign s1_go    = s1_valid_r && (!s1_idle_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_data_byte;
      s1_idle_r <= in_idle_event;
    end
  end

  // Scaled raw position, tracks raw_position_r through the scaler's product and result registers
  fcad_scale u_scale (
    .clk    (clk),
    .raw    (raw_position_r),
    .scaled (scaled)
  );

  assign angle_sum = {1'b0, scaled} + {{4{offset_r[25]}}, offset_r};

  always_comb begin
    if (byte_index_r < FRAME_LEN) begin
      status_nxt = ST_SHORT;
    end else if (check_word_r != running_crc_r) begin
      status_nxt = ST_CRC_ERR;
    end else begin
      status_nxt = ST_OK;
    end
  end

  // Frame state: collect bytes, close the frame on idle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r    <= 4'd0;
      running_crc_r   <= CRC_INIT;
      raw_position_r  <= 24'd0;
      check_word_r    <= 16'd0;
      good_position_r <= 24'd0;
      good_angle_r    <= 30'd0;
    end else if (s1_go) begin
      if (!s1_idle_r) begin
        if (byte_index_r < FRAME_LEN) begin
          if (byte_index_r < CRC_BYTES) begin
            running_crc_r <= crc_byte(running_crc_r, s1_byte_r);
          end
          case (byte_index_r)
            IDX_POS_HI:  raw_position_r[23:16] <= s1_byte_r;
            IDX_POS_MID: raw_position_r[15:8]  <= s1_byte_r;
            IDX_POS_LO:  raw_position_r[7:0]   <= s1_byte_r;
            IDX_CHK_LO:  check_word_r[7:0]     <= s1_byte_r;
            IDX_CHK_HI:  check_word_r[15:8]    <= s1_byte_r;
            default: ;
          endcase
          byte_index_r <= byte_index_r + 4'd1;
        end
      end else begin
        if (status_nxt == ST_OK) begin
          good_position_r <= raw_position_r;
          good_angle_r    <= angle_sum;
        end
        byte_index_r  <= 4'd0;
        running_crc_r <= CRC_INIT;
      end
    end
  end

  // Result register: load on idle, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_idle_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_idle_r) begin
      out_status_r <= status_nxt;
      if (status_nxt == ST_OK) begin
        out_turns_r <= raw_position_r[23:12];
        out_fine_r  <= raw_position_r[11:0];
        out_angle_r <= angle_sum;
      end else begin
        out_turns_r <= good_position_r[23:12];
        out_fine_r  <= good_position_r[11:0];
        out_angle_r <= good_angle_r;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_turns     = out_turns_r;
  assign out_fine      = out_fine_r;
  assign out_angle_q16 = out_angle_r;

endmodule

`default_nettype wire
